// ===== hw/rtl/llruq_pkg.sv =====
// Shared types and constants of the LLR uniform midpoint quantizer.
package llruq_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int LEVEL_W         = 8;
    localparam int HALF_W          = 8;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [HALF_W-1:0] HALF_LEVELS_RST = 8'd4;
    localparam logic [HALF_W-1:0] HALF_LEVELS_MIN = 8'd1;
    localparam logic [HALF_W-1:0] HALF_LEVELS_MAX = 8'd128;

    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_QUANT = 1'b1;

    // One classified request as it waits in the queue.
    typedef struct packed {
        logic                quant;
        logic                restart;
        logic [SAMPLE_W-1:0] sample;
    } t_item;

endpackage

// ===== hw/rtl/llruq_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
module llruq_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_op,
    input  logic                            i_first_of_block,
    input  logic [llruq_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                            i_pop,
    output logic                            o_avail,
    output llruq_pkg::t_item                o_item
);
    import llruq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;
    t_item              item_in;

    assign busy    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign push    = start && !busy;
    assign pop     = i_pop && o_avail;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        item_in.quant   = (i_op == OP_QUANT);
        item_in.restart = i_first_of_block;
        item_in.sample  = i_sample;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/llruq_div.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
module llruq_div #(
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW:0]   rem_sh;
    logic          ge;

    assign rem_sh     = {r_rem[DW-1:0], r_quo[DW-1]};
    assign ge         = (rem_sh >= {1'b0, r_div});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/llruq_back.sv =====
// Back end: range tracking, step and level divisions, midpoint and result register.
module llruq_back #(
    parameter int SAMPLE_BITS = llruq_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_avail,
    input  llruq_pkg::t_item                i_item,
    output logic                            o_pop,
    input  logic [llruq_pkg::HALF_W-1:0]    i_half_levels,
    input  logic                            i_cfg_write,
    output logic                            o_strobe,
    output logic [llruq_pkg::SAMPLE_W-1:0]  o_quant_value,
    output logic [llruq_pkg::LEVEL_W-1:0]   o_level_index
);
    import llruq_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int W   = SB + 1;
    localparam int DW  = (W > LEVEL_W + 1) ? W : LEVEL_W + 1;
    localparam int PW  = W + LEVEL_W;
    localparam int MW  = W + LEVEL_W + 3;
    localparam logic signed [MW-1:0] SAT_HI = MW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [MW-1:0] SAT_LO = ~SAT_HI;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STEP  = 3'd1;
    localparam logic [2:0] S_CLASS = 3'd2;
    localparam logic [2:0] S_LVL   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_MID   = 3'd5;

    logic [2:0]             r_state, n_state;
    logic signed [SB-1:0]   r_min, n_min;
    logic signed [SB-1:0]   r_max, n_max;
    logic [W-1:0]           r_step, n_step;
    logic                   r_step_valid, n_step_valid;
    logic signed [SB-1:0]   r_x, n_x;
    logic [LEVEL_W-1:0]     r_j, n_j;
    logic [PW-1:0]          r_prod, n_prod;
    logic                   r_strobe, n_strobe;
    logic [SAMPLE_W-1:0]    r_quant, n_quant;
    logic [LEVEL_W-1:0]     r_level, n_level;

    logic signed [SB-1:0]   x_in;
    logic [HALF_W-1:0]      h_eff;
    logic [HALF_W:0]        lc;
    logic [HALF_W:0]        lc_dec;
    logic [LEVEL_W-1:0]     lc_m1;
    logic signed [W-1:0]    min_w, max_w, x_w;
    logic [W-1:0]           abs_min, abs_max, range_sum, d_m1;

    logic                   div_start;
    logic [DW-1:0]          div_dividend;
    logic [DW-1:0]          div_divisor;
    logic                   div_done;
    logic [DW-1:0]          div_quo;

    logic signed [MW-1:0]   min_mw, prod_mw, step_mw, twice_mid, mid_half, mid;
    logic signed [SB-1:0]   sat_s;

    llruq_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign x_in = i_item.sample[SB-1:0];

    // Level count is twice the clamped half count, 2..256.
    always_comb begin
        priority if (i_half_levels == '0) begin
            h_eff = HALF_LEVELS_MIN;
        end else if (i_half_levels > HALF_LEVELS_MAX) begin
            h_eff = HALF_LEVELS_MAX;
        end else begin
            h_eff = i_half_levels;
        end
        lc     = {h_eff, 1'b0};
        lc_dec = lc - 1'b1;
        lc_m1  = lc_dec[LEVEL_W-1:0];
    end

    always_comb begin
        min_w     = W'(r_min);
        max_w     = W'(r_max);
        x_w       = W'(r_x);
        abs_min   = min_w[W-1] ? W'(-min_w) : min_w;
        abs_max   = max_w[W-1] ? W'(-max_w) : max_w;
        range_sum = abs_min + abs_max;
        d_m1      = x_w - min_w - W'(1);
    end

    // Twice the midpoint is exact; halving truncates toward zero, then saturate.
    always_comb begin
        min_mw    = MW'(r_min);
        prod_mw   = MW'(r_prod);
        step_mw   = MW'(r_step);
        twice_mid = (min_mw <<< 1) + (prod_mw <<< 1) + step_mw;
        mid_half  = twice_mid >>> 1;
        if (twice_mid[MW-1] && twice_mid[0]) begin
            mid = mid_half + MW'(1);
        end else begin
            mid = mid_half;
        end
        priority if (mid > SAT_HI) begin
            sat_s = SAT_HI[SB-1:0];
        end else if (mid < SAT_LO) begin
            sat_s = SAT_LO[SB-1:0];
        end else begin
            sat_s = mid[SB-1:0];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_min        = r_min;
        n_max        = r_max;
        n_step       = r_step;
        n_step_valid = r_step_valid;
        n_x          = r_x;
        n_j          = r_j;
        n_prod       = r_prod;
        n_strobe     = 1'b0;
        n_quant      = r_quant;
        n_level      = r_level;
        o_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = DW'(range_sum);
        div_divisor  = DW'(lc);

        unique case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    if (!i_item.quant) begin
                        if (i_item.restart) begin
                            n_min = x_in;
                            n_max = x_in;
                        end else begin
                            if (x_in < r_min) begin
                                n_min = x_in;
                            end
                            if (x_in > r_max) begin
                                n_max = x_in;
                            end
                        end
                        n_step_valid = 1'b0;
                    end else begin
                        n_x = x_in;
                        if (!r_step_valid) begin
                            div_start = 1'b1;
                            n_state   = S_STEP;
                        end else begin
                            n_state = S_CLASS;
                        end
                    end
                end
            end
            S_STEP: begin
                if (div_done) begin
                    n_step       = div_quo[W-1:0];
                    n_step_valid = 1'b1;
                    n_state      = S_CLASS;
                end
            end
            S_CLASS: begin
                if (r_x <= r_min) begin
                    n_j     = '0;
                    n_state = S_MUL;
                end else if (r_step == '0) begin
                    n_j     = lc_m1;
                    n_state = S_MUL;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DW'(d_m1);
                    div_divisor  = DW'(r_step);
                    n_state      = S_LVL;
                end
            end
            S_LVL: begin
                if (div_done) begin
                    n_j     = (div_quo > DW'(lc_m1)) ? lc_m1 : div_quo[LEVEL_W-1:0];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PW'(r_j) * PW'(r_step);
                n_state = S_MID;
            end
            S_MID: begin
                n_quant  = SAMPLE_W'(sat_s);
                n_level  = r_j;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_write) begin
            n_step_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_j     <= n_j;
        r_prod  <= n_prod;
        r_quant <= n_quant;
        r_level <= n_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min        <= '0;
            r_max        <= '0;
            r_step       <= '0;
            r_step_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_min        <= n_min;
            r_max        <= n_max;
            r_step       <= n_step;
            r_step_valid <= n_step_valid;
            r_strobe     <= n_strobe;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_quant_value = r_quant;
    assign o_level_index = r_level;

endmodule

// ===== hw/rtl/llr_uniform_midpoint_quantizer.sv =====
// Top level of the LLR uniform midpoint quantizer: queue front end, divider back end.
// A scan request is handled once at the head of the queue and gives no result. A quantize
// request goes through the step division (only when the step must be recomputed), the
// level division (skipped when the sample is at or below the minimum or the step is zero),
// one multiply and the midpoint stage; DW = max(SAMPLE_BITS+1, 9) is the radix-2 divider's
// bit count. Results appear for one cycle on o_strobe and cannot be stalled. Synchronous
// reset empties the queue, clears range and step state and sets half_levels to 4.
module llr_uniform_midpoint_quantizer #(
    parameter int SAMPLE_BITS = llruq_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_op,
    input  logic                            i_first_of_block,
    input  logic [llruq_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [llruq_pkg::HALF_W-1:0]    i_cfg_data,
    output logic                            o_strobe,
    output logic [llruq_pkg::SAMPLE_W-1:0]  o_quant_value,
    output logic [llruq_pkg::LEVEL_W-1:0]   o_level_index
);
    import llruq_pkg::*;

    // The half-level register. The user makes writes only while the block is idle; the block
    // does not enforce that. The port is always ready; a write also forces a step recompute.
    logic [HALF_W-1:0] r_half_levels;
    logic              cfg_write;

    // Queue handoff between the front end and the back end.
    logic  q_avail;
    logic  q_pop;
    t_item q_item;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_levels <= HALF_LEVELS_RST;
        end else if (cfg_write) begin
            r_half_levels <= i_cfg_data;
        end
    end

    // The front end takes a request whenever the queue has room; busy only means
    // the queue is full, so requests keep flowing while the back end divides.
    llruq_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_first_of_block (i_first_of_block),
        .i_sample         (i_sample),
        .i_pop            (q_pop),
        .o_avail          (q_avail),
        .o_item           (q_item)
    );

    // The back end works through the queue in order: scans update the range; quantize requests
    // go through the step division (when stale), the level division (for a sample above the
    // minimum and a nonzero step), one multiply and the midpoint stage into the result register.
    llruq_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (q_avail),
        .i_item        (q_item),
        .o_pop         (q_pop),
        .i_half_levels (r_half_levels),
        .i_cfg_write   (cfg_write),
        .o_strobe      (o_strobe),
        .o_quant_value (o_quant_value),
        .o_level_index (o_level_index)
    );

endmodule

// ===== tb/tb_llr_uniform_midpoint_quantizer.sv =====
// Self-checking testbench for the LLR uniform midpoint quantizer: directed and random requests.
module tb_llr_uniform_midpoint_quantizer;
    timeunit 1ns;
    timeprecision 1ps;

    import llruq_pkg::*;

    // One predicted quantizer output, in the order the block must deliver it.
    typedef struct packed {
        logic [SAMPLE_W-1:0] quant_value;
        logic [LEVEL_W-1:0]  level_index;
    } t_quant_result;

    localparam int LLR_MAX      = 32767;
    localparam int LLR_MIN      = -32768;
    localparam int SETTLE_TICKS = 60;   // time for trailing scans to drain
    localparam int PHASE_ITEMS  = 125;

    // Every input starts at a known value.
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                start            = 1'b0;
    logic                busy;
    logic                i_op             = OP_SCAN;
    logic                i_first_of_block = 1'b0;
    logic [SAMPLE_W-1:0] i_sample         = '0;
    logic                i_cfg_valid      = 1'b0;
    logic                o_cfg_ready;
    logic [HALF_W-1:0]   i_cfg_data       = '0;
    logic                o_strobe;
    logic [SAMPLE_W-1:0] o_quant_value;
    logic [LEVEL_W-1:0]  o_level_index;

    llr_uniform_midpoint_quantizer i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_first_of_block (i_first_of_block),
        .i_sample         (i_sample),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_quant_value    (o_quant_value),
        .o_level_index    (o_level_index)
    );

    // Requests waiting to be driven, and the quantizer outputs still owed by the block.
    t_item         llr_req_q[$];
    t_quant_result quant_expected[$];
    int            llr_sent   = 0;
    int            llr_taken  = 0;
    int            mismatches = 0;
    int            idle_pct   = 0;
    bit            req_taken  = 1'b0;

    // Predictor state: the range of the current block, the step and the level register.
    logic [HALF_W-1:0] model_half    = HALF_LEVELS_RST;
    int                model_min     = 0;
    int                model_max     = 0;
    int unsigned       model_step    = 0;
    bit                model_step_ok = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // The level register is clamped to 1..128, so the level count runs from 2 to 256.
    function automatic int unsigned level_count(logic [HALF_W-1:0] half);
        int unsigned n;
        n = half;
        if (n == 0) n = 1;
        if (n > 128) n = 128;
        return 2 * n;
    endfunction

    // Apply one accepted request to the predictor. A scan sets or widens the range and invalidates
    // the step; a quantize request recomputes the step if needed and owes one result.
    task automatic predict_request(logic quant, logic restart, logic [SAMPLE_W-1:0] raw);
        int            x;
        int unsigned   lc;
        int unsigned   lvl;
        int unsigned   offset;
        int unsigned   span;
        longint        mid;
        t_quant_result res;
        x  = $signed(raw);
        lc = level_count(model_half);
        if (quant == OP_SCAN) begin
            if (restart) begin
                model_min = x;
                model_max = x;
            end else begin
                if (x < model_min) model_min = x;
                if (x > model_max) model_max = x;
            end
            model_step_ok = 1'b0;
        end else begin
            if (!model_step_ok) begin
                span = (model_min < 0 ? -model_min : model_min)
                     + (model_max < 0 ? -model_max : model_max);
                model_step    = (span / lc) & 32'h1FFFF;
                model_step_ok = 1'b1;
            end
            // Below or at the minimum the sample takes level 0; with a zero step anything
            // above the minimum goes to the top level; otherwise the first level whose
            // upper edge it does not exceed, clamped to the top level.
            if (x <= model_min) begin
                lvl = 0;
            end else begin
                offset = x - model_min;
                if (model_step == 0) begin
                    lvl = lc - 1;
                end else begin
                    lvl = (offset + model_step - 1) / model_step - 1;
                    if (lvl > lc - 1) lvl = lc - 1;
                end
            end
            // Twice the midpoint is exact; halving it truncates toward zero.
            mid = (2 * (longint'(model_min) + longint'(lvl) * longint'(model_step))
                   + longint'(model_step)) / 2;
            if (mid > LLR_MAX) mid = LLR_MAX;
            if (mid < LLR_MIN) mid = LLR_MIN;
            res.quant_value = mid[SAMPLE_W-1:0];
            res.level_index = lvl[LEVEL_W-1:0];
            quant_expected.push_back(res);
        end
    endtask

    // Driver: at each falling edge, once the presented request has gone (or none is
    // up), present the next one unless this cycle is chosen to stay idle.
    always @(negedge i_clk) begin : drive_requests
        t_item nxt;
        if (i_rst_n && (!start || req_taken)) begin
            if (llr_req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = llr_req_q.pop_front();
                start            <= 1'b1;
                i_op             <= nxt.quant;
                i_first_of_block <= nxt.restart;
                i_sample         <= nxt.sample;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: at each rising edge, check a strobed result against the oldest
    // expectation, then feed an accepted request to the predictor.
    always @(posedge i_clk) begin : watch_quantizer
        t_quant_result want;
        if (i_rst_n && o_strobe) begin
            if (quant_expected.size() == 0) begin
                $error("unexpected result: quant_value %0d, level_index %0d",
                       $signed(o_quant_value), o_level_index);
                mismatches++;
            end else begin
                want = quant_expected.pop_front();
                if (o_quant_value !== want.quant_value) begin
                    $error("quant_value mismatch: expected %0d, actual %0d",
                           $signed(want.quant_value), $signed(o_quant_value));
                    mismatches++;
                end
                if (o_level_index !== want.level_index) begin
                    $error("level_index mismatch: expected %0d, actual %0d",
                           want.level_index, o_level_index);
                    mismatches++;
                end
            end
        end
        req_taken = i_rst_n && start && !busy;
        if (req_taken) begin
            predict_request(i_op, i_first_of_block, i_sample);
            llr_taken++;
        end
    end

    task automatic queue_request(logic quant, logic restart, int llr);
        t_item it;
        it.quant   = quant;
        it.restart = restart;
        it.sample  = 16'(llr);
        llr_req_q.push_back(it);
        llr_sent++;
    endtask

    function automatic int clamp_llr(int v);
        if (v > LLR_MAX) return LLR_MAX;
        if (v < LLR_MIN) return LLR_MIN;
        return v;
    endfunction

    function automatic int random_llr();
        logic signed [SAMPLE_W-1:0] v;
        v = 16'($urandom());
        return v;
    endfunction

    // Scan values of one block: full-range noise, a cluster around some center (small
    // steps, many levels in use), or the corner values of the sample field.
    function automatic int scan_llr(int style, int centre, int spread);
        if (style == 0) return random_llr();
        if (style == 1) return clamp_llr(centre + int'($urandom_range(2 * spread)) - spread);
        case ($urandom_range(4))
            0:       return LLR_MIN;
            1:       return LLR_MAX;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    // One well-formed block: a scan pass that opens with a restart, then one or two
    // quantize passes over values drawn from the block, around its range, or anywhere.
    task automatic queue_block(inout int count);
        int style;
        int centre;
        int spread;
        int lo;
        int hi;
        int v;
        int n_scan;
        int passes;
        int pick;
        int seen[$];
        style  = $urandom_range(2);
        centre = random_llr();
        spread = ($urandom_range(3) == 0) ? $urandom_range(1, 20000) : $urandom_range(1, 400);
        n_scan = $urandom_range(1, 10);
        for (int i = 0; i < n_scan; i++) begin
            v = scan_llr(style, centre, spread);
            if (i == 0 || v < lo) lo = v;
            if (i == 0 || v > hi) hi = v;
            seen.push_back(v);
            queue_request(OP_SCAN, i == 0, v);
        end
        count += n_scan;
        passes = ($urandom_range(9) == 0) ? 2 : 1;
        repeat (passes) begin
            repeat ($urandom_range(1, 10)) begin
                pick = $urandom_range(9);
                if (pick < 4)
                    v = seen[$urandom_range(seen.size() - 1)];
                else if (pick < 8)
                    v = clamp_llr(lo - 3 + int'($urandom_range(hi - lo + 6)));
                else
                    v = random_llr();
                queue_request(OP_QUANT, 1'($urandom_range(1)), v);
                count++;
            end
        end
    endtask

    // Mostly well-formed blocks; the rest is loose requests with random fields, which
    // also gives scans without a restart and quantize passes on a stale range.
    task automatic queue_phase(int n_items);
        int count;
        count = 0;
        while (count < n_items) begin
            if ($urandom_range(99) < 80) begin
                queue_block(count);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    queue_request(1'($urandom_range(1)), 1'($urandom_range(1)), random_llr());
                    count++;
                end
            end
        end
    endtask

    // Wait until every queued request is taken and every result has come back, then
    // let trailing scans drain through the block.
    task automatic wait_quiet();
        while (llr_taken != llr_sent) @(posedge i_clk);
        while (quant_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Write half_levels while the block is idle; the predictor takes the new value at
    // the edge that completes the handshake.
    task automatic write_half_levels(logic [HALF_W-1:0] half);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= half;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_half    = half;
        model_step_ok = 1'b0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : run_test
        logic [HALF_W-1:0] half_seq[6];
        int                idle_seq[6];
        half_seq = '{HALF_LEVELS_MIN, HALF_LEVELS_MAX, 8'd0, 8'd255, 8'd0, 8'd2};
        idle_seq = '{0, 87, 0, 31, 87, 0};
        half_seq[4] = HALF_W'($urandom_range(3, 127));

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset level count of 8.
        // Quantize before any scan: the range is zero, so the step is zero.
        queue_request(OP_QUANT, 1'b0, 0);
        queue_request(OP_QUANT, 1'b0, 5);
        queue_request(OP_QUANT, 1'b1, LLR_MIN);
        // Full-scale range, with both sample extremes and the first level edge.
        queue_request(OP_SCAN, 1'b1, LLR_MIN);
        queue_request(OP_SCAN, 1'b0, LLR_MAX);
        queue_request(OP_QUANT, 1'b0, LLR_MIN);
        queue_request(OP_QUANT, 1'b0, LLR_MAX);
        queue_request(OP_QUANT, 1'b0, 0);
        queue_request(OP_QUANT, 1'b0, -1);
        queue_request(OP_QUANT, 1'b0, -24577);
        queue_request(OP_QUANT, 1'b0, -24576);
        // Positive range whose upper midpoints overflow and saturate, and samples
        // below and at the minimum.
        queue_request(OP_SCAN, 1'b1, 10000);
        queue_request(OP_SCAN, 1'b0, LLR_MAX);
        queue_request(OP_QUANT, 1'b0, LLR_MAX);
        queue_request(OP_QUANT, 1'b0, 9999);
        queue_request(OP_QUANT, 1'b0, 10000);
        // A single-sample block still gives a nonzero step, since the step comes from |min| + |max|.
        queue_request(OP_SCAN, 1'b1, 16'h1234);
        queue_request(OP_QUANT, 1'b0, 16'h1234);
        queue_request(OP_QUANT, 1'b0, 16'h1235);
        // A restart in the middle of a scan pass discards the earlier samples.
        queue_request(OP_SCAN, 1'b1, -5);
        queue_request(OP_SCAN, 1'b1, 7);
        queue_request(OP_QUANT, 1'b0, 6);
        queue_request(OP_QUANT, 1'b0, 7);
        wait_quiet();

        // Random phases, each with its level count and sender idling set anew. The block
        // cannot hold results off, so only the sender side idles.
        for (int p = 0; p < 6; p++) begin
            write_half_levels(half_seq[p]);
            idle_pct = idle_seq[p];
            queue_phase(PHASE_ITEMS);
            wait_quiet();
        end

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== llr_uniform_midpoint_quantizer.f =====
hw/rtl/llruq_pkg.sv
hw/rtl/llruq_front.sv
hw/rtl/llruq_div.sv
hw/rtl/llruq_back.sv
hw/rtl/llr_uniform_midpoint_quantizer.sv
tb/tb_llr_uniform_midpoint_quantizer.sv
